FILE: rtl/bss_pkg.sv
package bss_pkg;

  localparam int MAP_BITS  = 256;
  localparam int WORD_BITS = (MAP_BITS < 16) ? MAP_BITS : 16;
  localparam int WORDS     = MAP_BITS / WORD_BITS;
  localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(MAP_BITS + 1);
  localparam int POS_W     = (CNT_W > 9) ? CNT_W : 9;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [2:0] {
    REQ_QUERY   = 3'd0,
    REQ_SET     = 3'd1,
    REQ_CLEAR   = 3'd2,
    REQ_RESTART = 3'd3,
    REQ_NEXT    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  function automatic logic [WB_W:0] word_ones(word_t w);
    logic [WB_W:0] c;
    c = '0;
    for (int j = 0; j < WORD_BITS; j++) c = c + (WB_W + 1)'(w[j]);
    return c;
  endfunction

  function automatic logic [WB_W-1:0] lowest_set(word_t w);
    logic [WB_W-1:0] r;
    r = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (w[j]) r = WB_W'(j);
    end
    return r;
  endfunction

endpackage

FILE: rtl/bss_ram.sv
module bss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bitset_store_with_scan.sv
// A new request is taken only in the idle state, after the previous result is loaded;
// every request sweeps all map words through the single read port of the word memory,
// one 16-bit word per cycle.
// Reset: size_in_use returns to 256, the iterator cursor to 0, and per-word valid
// flags clear so the whole map reads as zero at once; no clearing pass is needed.
module bitset_store_with_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            req_type,
  input  logic [7:0]            bit_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  bit_value,
  output logic [8:0]            ones_count,
  output logic                  any_set,
  output logic [7:0]            first_index,
  output logic [8:0]            iter_position,
  output logic                  iter_valid,
  output logic                  out_of_range,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [8:0]            cfg_data
);
  import bss_pkg::*;

  state_t state, state_next;

  logic [8:0] size_in_use;
  pos_t       eff_size;
  pos_t       size_ext;
  pos_t       cursor;

  logic [2:0]      req_q;
  logic            wr_q;
  logic            look_q;
  logic            oor_q;
  addr_t           tgt_word;
  logic [WB_W-1:0] tgt_bit;

  addr_t rd_ptr;
  addr_t proc_ptr;
  logic  proc_vld;
  logic  rd_en;
  word_t rd_data;

  logic [WORDS-1:0] row_valid;

  pos_t acc_cnt;
  pos_t acc_first;
  logic acc_found;
  pos_t acc_ipos;
  logic acc_ifound;
  logic acc_bitv;

  logic  accept;
  logic  load;
  logic  in_range;
  logic  is_bit_req;
  word_t raw_word;
  word_t mod_word;
  word_t act_mask;
  word_t it_mask;
  word_t m_word;
  word_t mi_word;
  pos_t  base;
  logic  hit;
  logic  wr_en;

  assign cfg_ready = 1'b1;
  assign size_ext  = pos_t'(size_in_use);
  assign eff_size  = (size_ext > pos_t'(MAP_BITS)) ? pos_t'(MAP_BITS) : size_ext;

  assign accept     = in_valid && !in_stall;
  assign is_bit_req = (req_type == REQ_QUERY) || (req_type == REQ_SET) ||
                      (req_type == REQ_CLEAR);
  assign in_range   = pos_t'(bit_index) < eff_size;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (rd_ptr == addr_t'(WORDS - 1)) state_next = S_DRAIN;
      S_DRAIN: state_next = S_FIN;
      S_FIN:   if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    load     = 1'b0;
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_SCAN:  rd_en = 1'b1;
      S_DRAIN: ;
      S_FIN:   load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) size_in_use <= 9'd256;
    else if (cfg_valid && cfg_ready) size_in_use <= cfg_data;
  end

  // latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_type;
      look_q   <= is_bit_req && in_range;
      wr_q     <= ((req_type == REQ_SET) || (req_type == REQ_CLEAR)) && in_range;
      oor_q    <= is_bit_req && !in_range;
      tgt_word <= addr_t'(pos_t'(bit_index) >> WB_W);
      tgt_bit  <= bit_index[WB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)     rd_ptr <= '0;
    else if (rd_en) rd_ptr <= rd_ptr + addr_t'(1);
    proc_ptr <= rd_ptr;
  end

  bss_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (wr_en),
    .waddr(proc_ptr),
    .wdata(mod_word),
    .re   (rd_en),
    .raddr(rd_ptr),
    .rdata(rd_data)
  );

  // word under processing: modify, mask to the active range, reduce
  always_comb begin
    raw_word = row_valid[proc_ptr] ? rd_data : '0;
    hit      = proc_vld && (proc_ptr == tgt_word);
    mod_word = raw_word;
    if (hit && wr_q) mod_word[tgt_bit] = (req_q == REQ_SET);
    base = pos_t'(proc_ptr) << WB_W;
    for (int j = 0; j < WORD_BITS; j++) begin
      act_mask[j] = (base + pos_t'(j)) < eff_size;
      it_mask[j]  = (base + pos_t'(j)) >= cursor;
    end
    m_word  = mod_word & act_mask;
    mi_word = m_word & it_mask;
    wr_en   = hit && wr_q;
  end

  always_ff @(posedge clk) begin
    if (rst) row_valid <= '0;
    else if (wr_en) row_valid[proc_ptr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_cnt    <= '0;
      acc_first  <= '0;
      acc_found  <= 1'b0;
      acc_ipos   <= '0;
      acc_ifound <= 1'b0;
      acc_bitv   <= 1'b0;
    end else if (proc_vld) begin
      acc_cnt <= acc_cnt + pos_t'(word_ones(m_word));
      if (!acc_found && (m_word != '0)) begin
        acc_found <= 1'b1;
        acc_first <= base + pos_t'(lowest_set(m_word));
      end
      if (!acc_ifound && (mi_word != '0)) begin
        acc_ifound <= 1'b1;
        acc_ipos   <= base + pos_t'(lowest_set(mi_word));
      end
      if (hit && look_q) acc_bitv <= raw_word[tgt_bit];
    end
  end

  // iterator cursor moves as the result beat is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (load) begin
      if (req_q == REQ_RESTART) begin
        cursor <= '0;
      end else if (req_q == REQ_NEXT) begin
        cursor <= acc_ifound ? acc_ipos + pos_t'(1) : eff_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bit_value    <= acc_bitv;
      ones_count   <= 9'(acc_cnt);
      any_set      <= acc_found;
      first_index  <= 8'(acc_first);
      out_of_range <= oor_q;
      if (req_q == REQ_NEXT) begin
        iter_position <= acc_ifound ? 9'(acc_ipos) : 9'(eff_size);
        iter_valid    <= acc_ifound;
      end else begin
        iter_position <= '0;
        iter_valid    <= 1'b0;
      end
    end
  end

  a_write_only_set_clear: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((req_q == REQ_SET) || (req_q == REQ_CLEAR)) && !oor_q)
    else $error("map write outside an in-range set or clear");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (acc_cnt <= eff_size))
    else $error("population count exceeds active size");

  a_found_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (acc_found == (acc_cnt != '0)))
    else $error("any-set flag disagrees with count");

  a_iter_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && acc_ifound |-> (acc_ipos < eff_size) && (acc_ipos >= cursor))
    else $error("iterator hit outside cursor window");

endmodule
